>>> src/assert_macros.svh
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Check a property on every rising clk_i edge outside reset.
`define ERM_ASSERT(name, prop) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("assertion failed");

// Check that ante implies cons in the same cycle.
`define ERM_ASSERT_IMP(name, ante, cons) \
  `ERM_ASSERT(name, (ante) |-> (cons))

`else

`define ERM_ASSERT(name, prop)
`define ERM_ASSERT_IMP(name, ante, cons)

`endif

`endif

>>> src/erm_pkg.sv
package erm_pkg;

  localparam int unsigned ANGLE_BITS = 16;
  localparam int unsigned FRAC_BITS  = 14;
  localparam int unsigned FIELD_W    = 16;

  // Internal series arithmetic runs in Q30.
  localparam int unsigned QW     = 30;
  localparam int unsigned ACC_W  = QW + 1;
  localparam int unsigned RCP_W  = QW + 1;
  localparam int unsigned OFF_W  = ANGLE_BITS - 2;
  localparam int unsigned RND_SH = QW - FRAC_BITS;

  localparam int unsigned TRIG_W = FRAC_BITS + 2;
  localparam int unsigned PRD_W  = 2 * TRIG_W;

  localparam int unsigned TERMS      = 6;
  localparam int unsigned SC_STAGES  = 2 * TERMS + 5;
  localparam int unsigned MAT_STAGES = 4;
  localparam int unsigned NUM_STAGES = SC_STAGES + MAT_STAGES;

  localparam logic [31:0]      PI_Q30  = 32'd3373259426;
  localparam logic [ACC_W-1:0] Q30_ONE = ACC_W'(64'd1 << QW);

  // Factorial steps of the sine and cosine series.
  localparam logic [7:0] SIN_DIV [TERMS] = '{8'd6, 8'd20, 8'd42, 8'd72, 8'd110, 8'd156};
  localparam logic [7:0] COS_DIV [TERMS] = '{8'd2, 8'd12, 8'd30, 8'd56, 8'd90, 8'd132};

  localparam int unsigned SIN_SH [TERMS] = '{
    QW + $clog2(SIN_DIV[0]), QW + $clog2(SIN_DIV[1]), QW + $clog2(SIN_DIV[2]),
    QW + $clog2(SIN_DIV[3]), QW + $clog2(SIN_DIV[4]), QW + $clog2(SIN_DIV[5])
  };
  localparam int unsigned COS_SH [TERMS] = '{
    QW + $clog2(COS_DIV[0]), QW + $clog2(COS_DIV[1]), QW + $clog2(COS_DIV[2]),
    QW + $clog2(COS_DIV[3]), QW + $clog2(COS_DIV[4]), QW + $clog2(COS_DIV[5])
  };

  // Rounded-up reciprocals; exact floor quotient for any 30-bit dividend.
  localparam logic [RCP_W-1:0] SIN_RCP [TERMS] = '{
    RCP_W'(((64'd1 << SIN_SH[0]) + 64'(SIN_DIV[0]) - 64'd1) / SIN_DIV[0]),
    RCP_W'(((64'd1 << SIN_SH[1]) + 64'(SIN_DIV[1]) - 64'd1) / SIN_DIV[1]),
    RCP_W'(((64'd1 << SIN_SH[2]) + 64'(SIN_DIV[2]) - 64'd1) / SIN_DIV[2]),
    RCP_W'(((64'd1 << SIN_SH[3]) + 64'(SIN_DIV[3]) - 64'd1) / SIN_DIV[3]),
    RCP_W'(((64'd1 << SIN_SH[4]) + 64'(SIN_DIV[4]) - 64'd1) / SIN_DIV[4]),
    RCP_W'(((64'd1 << SIN_SH[5]) + 64'(SIN_DIV[5]) - 64'd1) / SIN_DIV[5])
  };
  localparam logic [RCP_W-1:0] COS_RCP [TERMS] = '{
    RCP_W'(((64'd1 << COS_SH[0]) + 64'(COS_DIV[0]) - 64'd1) / COS_DIV[0]),
    RCP_W'(((64'd1 << COS_SH[1]) + 64'(COS_DIV[1]) - 64'd1) / COS_DIV[1]),
    RCP_W'(((64'd1 << COS_SH[2]) + 64'(COS_DIV[2]) - 64'd1) / COS_DIV[2]),
    RCP_W'(((64'd1 << COS_SH[3]) + 64'(COS_DIV[3]) - 64'd1) / COS_DIV[3]),
    RCP_W'(((64'd1 << COS_SH[4]) + 64'(COS_DIV[4]) - 64'd1) / COS_DIV[4]),
    RCP_W'(((64'd1 << COS_SH[5]) + 64'(COS_DIV[5]) - 64'd1) / COS_DIV[5])
  };

  typedef struct packed {
    logic [FIELD_W-1:0] yaw_angle;
    logic [FIELD_W-1:0] pitch_angle;
    logic [FIELD_W-1:0] roll_angle;
  } erm_req_t;

  typedef struct packed {
    logic signed [FIELD_W-1:0] m0;
    logic signed [FIELD_W-1:0] m1;
    logic signed [FIELD_W-1:0] m2;
    logic signed [FIELD_W-1:0] m3;
    logic signed [FIELD_W-1:0] m4;
    logic signed [FIELD_W-1:0] m5;
    logic signed [FIELD_W-1:0] m6;
    logic signed [FIELD_W-1:0] m7;
    logic signed [FIELD_W-1:0] m8;
  } erm_rsp_t;

  // Q30 product, round half up.
  function automatic logic [QW-1:0] q30_mul(logic [ACC_W-1:0] a, logic [QW-1:0] b);
    logic [2*QW:0] p;
    p = (2*QW+1)'(a) * (2*QW+1)'(b) + ((2*QW+1)'(1) << (QW - 1));
    return p[2*QW-1:QW];
  endfunction

  // Floor divide by a constant through its reciprocal.
  function automatic logic [QW-1:0] div_const(logic [QW-1:0] n, logic [RCP_W-1:0] rcp,
                                               int unsigned sh);
    logic [QW+RCP_W-1:0] p;
    p = (QW+RCP_W)'(n) * (QW+RCP_W)'(rcp);
    return QW'(p >> sh);
  endfunction

  // Q30 to FRAC_BITS, round half up.
  function automatic logic [FRAC_BITS:0] round_q30(logic [ACC_W-1:0] v);
    logic [ACC_W+1:0] t;
    t = (ACC_W+2)'({v, 1'b0}) + ((ACC_W+2)'(1) << RND_SH);
    return (FRAC_BITS+1)'(t >> (RND_SH + 1));
  endfunction

  // Round half away from zero to FRAC_BITS, clamp to plus or minus one.
  function automatic logic signed [TRIG_W-1:0] round_sat(logic signed [PRD_W-1:0] v);
    logic [PRD_W-1:0] mag;
    logic [PRD_W-1:0] r;
    mag = v[PRD_W-1] ? PRD_W'(-v) : PRD_W'(v);
    r = (mag + (PRD_W'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
    if (r > (PRD_W'(1) << FRAC_BITS)) begin
      r = PRD_W'(1) << FRAC_BITS;
    end
    return v[PRD_W-1] ? -TRIG_W'(r) : TRIG_W'(r);
  endfunction

endpackage

>>> src/erm_sincos.sv
module erm_sincos (
  input  logic                                clk_i,
  input  logic [erm_pkg::FIELD_W-1:0]         angle_i,
  input  logic [erm_pkg::SC_STAGES-1:0]       load_i,
  output logic signed [erm_pkg::TRIG_W-1:0]   sin_o,
  output logic signed [erm_pkg::TRIG_W-1:0]   cos_o
);
  import erm_pkg::*;

  localparam int unsigned LAST = 2 * TERMS + 2;

  localparam logic [1:0] QUAD_I   = 2'd0;
  localparam logic [1:0] QUAD_II  = 2'd1;
  localparam logic [1:0] QUAD_III = 2'd2;
  localparam logic [1:0] QUAD_IV  = 2'd3;

  typedef struct packed {
    logic [1:0]       quad;
    logic             mirror;
    logic [QW-1:0]    x2;
    logic [ACC_W-1:0] ss;
    logic [ACC_W-1:0] cc;
    logic [ACC_W-1:0] ts;
    logic [ACC_W-1:0] tc;
  } sc_stage_t;

  sc_stage_t st_d [LAST+1];
  sc_stage_t st_q [LAST+1];

  logic [ANGLE_BITS-1:0]    ang;
  logic [OFF_W-1:0]         off;
  logic                     mir;
  logic [OFF_W+31:0]        prod;
  logic [ACC_W-1:0]         ss_fin;
  logic [ACC_W-1:0]         cc_fin;
  logic [FRAC_BITS:0]       s_rnd;
  logic [FRAC_BITS:0]       c_rnd;
  logic [FRAC_BITS:0]       fs_d;
  logic [FRAC_BITS:0]       fc_d;
  logic [FRAC_BITS:0]       fs_q;
  logic [FRAC_BITS:0]       fc_q;
  logic [1:0]               fq_q;
  logic signed [TRIG_W-1:0] sv;
  logic signed [TRIG_W-1:0] cv;
  logic signed [TRIG_W-1:0] sin_d;
  logic signed [TRIG_W-1:0] cos_d;
  logic signed [TRIG_W-1:0] sin_q;
  logic signed [TRIG_W-1:0] cos_q;

  always_comb begin
    // Split into quadrant and offset, fold the upper eighth down.
    ang = ANGLE_BITS'(angle_i);
    off = ang[OFF_W-1:0];
    mir = off > (OFF_W'(1) << (OFF_W - 1));
    st_d[0]        = '0;
    st_d[0].quad   = ang[ANGLE_BITS-1 -: 2];
    st_d[0].mirror = mir;
    st_d[0].ts     = mir ? ACC_W'(((OFF_W+1)'(1) << OFF_W) - (OFF_W+1)'(off))
                         : ACC_W'(off);

    // Scale the offset to radians in Q30.
    st_d[1] = st_q[0];
    prod = (OFF_W+32)'(st_q[0].ts[OFF_W-1:0]) * (OFF_W+32)'(PI_Q30)
         + ((OFF_W+32)'(1) << OFF_W);
    st_d[1].ts = ACC_W'(prod >> (ANGLE_BITS - 1));

    st_d[2]    = st_q[1];
    st_d[2].x2 = q30_mul(st_q[1].ts, st_q[1].ts[QW-1:0]);
    st_d[2].ss = st_q[1].ts;
    st_d[2].cc = Q30_ONE;
    st_d[2].tc = Q30_ONE;

    // Alternate term product and factorial divide; fold in the previous term.
    for (int j = 0; j < TERMS; j++) begin
      st_d[3+2*j]    = st_q[2+2*j];
      st_d[3+2*j].ts = ACC_W'(q30_mul(st_q[2+2*j].ts, st_q[2+2*j].x2));
      st_d[3+2*j].tc = ACC_W'(q30_mul(st_q[2+2*j].tc, st_q[2+2*j].x2));
      if (j > 0) begin
        if (j[0]) begin
          st_d[3+2*j].ss = st_q[2+2*j].ss - st_q[2+2*j].ts;
          st_d[3+2*j].cc = st_q[2+2*j].cc - st_q[2+2*j].tc;
        end else begin
          st_d[3+2*j].ss = st_q[2+2*j].ss + st_q[2+2*j].ts;
          st_d[3+2*j].cc = st_q[2+2*j].cc + st_q[2+2*j].tc;
        end
      end

      st_d[4+2*j]    = st_q[3+2*j];
      st_d[4+2*j].ts = ACC_W'(div_const(st_q[3+2*j].ts[QW-1:0], SIN_RCP[j], SIN_SH[j]));
      st_d[4+2*j].tc = ACC_W'(div_const(st_q[3+2*j].tc[QW-1:0], COS_RCP[j], COS_SH[j]));
    end

    // Last term adds; round and undo the fold.
    ss_fin = st_q[LAST].ss + st_q[LAST].ts;
    cc_fin = st_q[LAST].cc + st_q[LAST].tc;
    s_rnd  = round_q30(ss_fin);
    c_rnd  = round_q30(cc_fin);
    fs_d   = st_q[LAST].mirror ? c_rnd : s_rnd;
    fc_d   = st_q[LAST].mirror ? s_rnd : c_rnd;

    sv = TRIG_W'(fs_q);
    cv = TRIG_W'(fc_q);
    unique case (fq_q)
      QUAD_I: begin
        sin_d = sv;
        cos_d = cv;
      end
      QUAD_II: begin
        sin_d = cv;
        cos_d = -sv;
      end
      QUAD_III: begin
        sin_d = -sv;
        cos_d = -cv;
      end
      QUAD_IV: begin
        sin_d = -cv;
        cos_d = sv;
      end
      default: begin
        sin_d = sv;
        cos_d = cv;
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k <= LAST; k++) begin
      if (load_i[k]) begin
        st_q[k] <= st_d[k];
      end
    end
    if (load_i[LAST+1]) begin
      fs_q <= fs_d;
      fc_q <= fc_d;
      fq_q <= st_q[LAST].quad;
    end
    if (load_i[LAST+2]) begin
      sin_q <= sin_d;
      cos_q <= cos_d;
    end
  end

  assign sin_o = sin_q;
  assign cos_o = cos_q;

endmodule

>>> src/euler_to_rotation_matrix_unit.sv
// Euler angles to 3x3 rotation matrix. Each request carries yaw, pitch and
// roll as 16-bit binary angles (65536 is one turn) and returns the nine
// matrix entries m0..m8 in row-major order as signed Q1.14, rounded and
// clamped to plus or minus one. The block is a 21-stage pipeline: 17 stages
// of sine/cosine per angle (quadrant fold, scaling to radians, squaring, six
// series terms each a Q30 multiply stage followed by a reciprocal-multiply
// divide stage, rounding with the octant swap, and quadrant signs) and 4
// stages of matrix products and rounding. One request is taken every cycle
// unless the output is stalled while every stage is full; the result is
// registered in the last stage. A stalled output only halts the stages behind
// it, so bubbles are squeezed out and requests keep entering until every
// stage holds one.
`include "assert_macros.svh"

module euler_to_rotation_matrix_unit (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  erm_pkg::erm_req_t in_data_i,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output erm_pkg::erm_rsp_t out_data_o
);
  import erm_pkg::*;

  typedef struct packed {
    logic signed [PRD_W-1:0]  sysp;
    logic signed [PRD_W-1:0]  cysp;
    logic signed [PRD_W-1:0]  cycr;
    logic signed [PRD_W-1:0]  sycr;
    logic signed [PRD_W-1:0]  cpsr;
    logic signed [PRD_W-1:0]  cpcr;
    logic signed [PRD_W-1:0]  sysr;
    logic signed [PRD_W-1:0]  sycp;
    logic signed [PRD_W-1:0]  cycp;
    logic signed [PRD_W-1:0]  cysr;
    logic signed [TRIG_W-1:0] sp;
    logic signed [TRIG_W-1:0] sr;
    logic signed [TRIG_W-1:0] cr;
  } mat0_t;

  typedef struct packed {
    logic signed [TRIG_W-1:0] syp;
    logic signed [TRIG_W-1:0] cyp;
    logic signed [TRIG_W-1:0] m1;
    logic signed [TRIG_W-1:0] m4;
    logic signed [TRIG_W-1:0] m6;
    logic signed [TRIG_W-1:0] m7;
    logic signed [TRIG_W-1:0] m8;
    logic signed [PRD_W-1:0]  cycr;
    logic signed [PRD_W-1:0]  sycr;
    logic signed [PRD_W-1:0]  sysr;
    logic signed [PRD_W-1:0]  cysr;
    logic signed [TRIG_W-1:0] sr;
    logic signed [TRIG_W-1:0] cr;
  } mat1_t;

  typedef struct packed {
    logic signed [PRD_W-1:0]  t0;
    logic signed [PRD_W-1:0]  t2;
    logic signed [PRD_W-1:0]  t3;
    logic signed [PRD_W-1:0]  t5;
    logic signed [PRD_W-1:0]  cycr;
    logic signed [PRD_W-1:0]  sycr;
    logic signed [PRD_W-1:0]  sysr;
    logic signed [PRD_W-1:0]  cysr;
    logic signed [TRIG_W-1:0] m1;
    logic signed [TRIG_W-1:0] m4;
    logic signed [TRIG_W-1:0] m6;
    logic signed [TRIG_W-1:0] m7;
    logic signed [TRIG_W-1:0] m8;
  } mat2_t;

  logic [NUM_STAGES-1:0] valid_d;
  logic [NUM_STAGES-1:0] valid_q;
  logic [NUM_STAGES-1:0] vin;
  logic [NUM_STAGES-1:0] take;
  logic [NUM_STAGES-1:0] load;

  logic signed [TRIG_W-1:0] sy;
  logic signed [TRIG_W-1:0] cy;
  logic signed [TRIG_W-1:0] sp;
  logic signed [TRIG_W-1:0] cp;
  logic signed [TRIG_W-1:0] sr;
  logic signed [TRIG_W-1:0] cr;

  mat0_t    m0_d, m0_q;
  mat1_t    m1_d, m1_q;
  mat2_t    m2_d, m2_q;
  erm_rsp_t rsp_d, rsp_q;

  // A stage takes a new request when it or any stage after it is free, or when the output is ready.
  always_comb begin
    vin = {valid_q[NUM_STAGES-2:0], in_valid_i};
    for (int k = 0; k < NUM_STAGES; k++) begin
      take[k] = out_ready_i || !(&(valid_q | NUM_STAGES'((64'd1 << k) - 64'd1)));
    end
    load    = take & vin;
    valid_d = (take & vin) | (~take & valid_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o  = take[0];
  assign out_valid_o = valid_q[NUM_STAGES-1];

  erm_sincos u_yaw (
    .clk_i   (clk_i),
    .angle_i (in_data_i.yaw_angle),
    .load_i  (load[SC_STAGES-1:0]),
    .sin_o   (sy),
    .cos_o   (cy)
  );

  erm_sincos u_pitch (
    .clk_i   (clk_i),
    .angle_i (in_data_i.pitch_angle),
    .load_i  (load[SC_STAGES-1:0]),
    .sin_o   (sp),
    .cos_o   (cp)
  );

  erm_sincos u_roll (
    .clk_i   (clk_i),
    .angle_i (in_data_i.roll_angle),
    .load_i  (load[SC_STAGES-1:0]),
    .sin_o   (sr),
    .cos_o   (cr)
  );

  always_comb begin
    m0_d.sysp = PRD_W'(sy) * PRD_W'(sp);
    m0_d.cysp = PRD_W'(cy) * PRD_W'(sp);
    m0_d.cycr = PRD_W'(cy) * PRD_W'(cr);
    m0_d.sycr = PRD_W'(sy) * PRD_W'(cr);
    m0_d.cpsr = PRD_W'(cp) * PRD_W'(sr);
    m0_d.cpcr = PRD_W'(cp) * PRD_W'(cr);
    m0_d.sysr = PRD_W'(sy) * PRD_W'(sr);
    m0_d.sycp = PRD_W'(sy) * PRD_W'(cp);
    m0_d.cycp = PRD_W'(cy) * PRD_W'(cp);
    m0_d.cysr = PRD_W'(cy) * PRD_W'(sr);
    m0_d.sp   = sp;
    m0_d.sr   = sr;
    m0_d.cr   = cr;

    // Round the pitch partial products before the triple terms.
    m1_d.syp  = round_sat(m0_q.sysp);
    m1_d.cyp  = round_sat(m0_q.cysp);
    m1_d.m1   = round_sat(-m0_q.cpsr);
    m1_d.m4   = round_sat(m0_q.cpcr);
    m1_d.m6   = round_sat(m0_q.sycp);
    m1_d.m7   = m0_q.sp;
    m1_d.m8   = round_sat(m0_q.cycp);
    m1_d.cycr = m0_q.cycr;
    m1_d.sycr = m0_q.sycr;
    m1_d.sysr = m0_q.sysr;
    m1_d.cysr = m0_q.cysr;
    m1_d.sr   = m0_q.sr;
    m1_d.cr   = m0_q.cr;

    m2_d.t0   = PRD_W'(m1_q.syp) * PRD_W'(m1_q.sr);
    m2_d.t2   = PRD_W'(m1_q.cyp) * PRD_W'(m1_q.sr);
    m2_d.t3   = PRD_W'(m1_q.syp) * PRD_W'(m1_q.cr);
    m2_d.t5   = PRD_W'(m1_q.cyp) * PRD_W'(m1_q.cr);
    m2_d.cycr = m1_q.cycr;
    m2_d.sycr = m1_q.sycr;
    m2_d.sysr = m1_q.sysr;
    m2_d.cysr = m1_q.cysr;
    m2_d.m1   = m1_q.m1;
    m2_d.m4   = m1_q.m4;
    m2_d.m6   = m1_q.m6;
    m2_d.m7   = m1_q.m7;
    m2_d.m8   = m1_q.m8;

    rsp_d.m0 = FIELD_W'(round_sat(m2_q.cycr + m2_q.t0));
    rsp_d.m1 = FIELD_W'(m2_q.m1);
    rsp_d.m2 = FIELD_W'(round_sat(m2_q.t2 - m2_q.sycr));
    rsp_d.m3 = FIELD_W'(round_sat(m2_q.cysr - m2_q.t3));
    rsp_d.m4 = FIELD_W'(m2_q.m4);
    rsp_d.m5 = FIELD_W'(round_sat(-m2_q.sysr - m2_q.t5));
    rsp_d.m6 = FIELD_W'(m2_q.m6);
    rsp_d.m7 = FIELD_W'(m2_q.m7);
    rsp_d.m8 = FIELD_W'(m2_q.m8);
  end

  always_ff @(posedge clk_i) begin
    if (load[SC_STAGES]) begin
      m0_q <= m0_d;
    end
    if (load[SC_STAGES+1]) begin
      m1_q <= m1_d;
    end
    if (load[SC_STAGES+2]) begin
      m2_q <= m2_d;
    end
    if (load[SC_STAGES+3]) begin
      rsp_q <= rsp_d;
    end
  end

  assign out_data_o = rsp_q;

  `ERM_ASSERT_IMP(a_ready_when_drained, out_ready_i, in_ready_o)
  `ERM_ASSERT_IMP(a_stall_only_when_full, !in_ready_o, (&valid_q) && !out_ready_i)
  `ERM_ASSERT(a_request_count, rst_ni |=> ($countones(valid_q) ==
      $past($countones(valid_q)) + $past(int'(in_valid_i && in_ready_o)) -
      $past(int'(out_valid_o && out_ready_i))))

endmodule
